### hdl/rx_ring_packet_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef RX_RING_PACKET_DEFRAMER_MACROS_SVH
`define RX_RING_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RRPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rrpd_pkg.sv
package rrpd_pkg;

  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int LVL_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;
  localparam int PKT_BYTES  = 3;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBUG_ADDR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TABLE = 1'd1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } st_t;

  typedef struct packed {
    logic       packet_done;
    logic [3:0] pkt_address;
    logic [1:0] pkt_count;
    logic [1:0] pkt_bytes_read;
    logic [7:0] pkt_byte0;
    logic [7:0] pkt_byte1;
    logic [7:0] pkt_byte2;
    logic [5:0] fifo_level;
    logic       overflowed;
  } res_t;

  function automatic logic header_ok(input logic [7:0] h, input logic [3:0] dbg,
                                     input logic [31:0] tbl);
    logic [3:0] a;
    logic [1:0] c;
    logic [1:0] want;
    a    = h[7:4];
    c    = h[2:1];
    want = tbl[{a, 1'b0} +: 2];
    return !h[0] && ((a == dbg) || (want == c));
  endfunction

endpackage

### hdl/rrpd_ram.sv
module rrpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/rrpd_ctrl.sv
module rrpd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [7:0]           in_byte,
  input  logic [3:0]           debug_address,
  input  logic [31:0]          count_table,
  input  logic                 slot_free,
  output logic                 res_valid,
  output rrpd_pkg::res_t       res
);

  rrpd_pkg::st_t state_r, state_nxt;

  logic [rrpd_pkg::PTR_W-1:0] rp_r, rp_nxt, rp_inc;
  logic [rrpd_pkg::LVL_W-1:0] fl_r, fl_nxt, fl_dec;
  logic                       hunting_r, hunting_nxt;
  logic [3:0]                 cur_addr_r, cur_addr_nxt;
  logic [1:0]                 cur_cnt_r, cur_cnt_nxt;
  logic [1:0]                 bg_r, bg_nxt;
  logic [7:0]                 pkt_byte_r   [rrpd_pkg::PKT_BYTES];
  logic [7:0]                 pkt_byte_nxt [rrpd_pkg::PKT_BYTES];

  logic                       accept;
  logic [rrpd_pkg::SUM_W-1:0] slot_sum;
  logic [rrpd_pkg::PTR_W-1:0] wr_slot;
  logic                       ram_we;
  logic [7:0]                 ram_rdata;
  logic                       hdr_ok;
  logic                       done;
  logic                       ovf;

  assign in_ready = (state_r == rrpd_pkg::ST_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;

  assign slot_sum = {1'b0, rp_r} + rrpd_pkg::SUM_W'(fl_r);
  assign wr_slot  = (slot_sum >= rrpd_pkg::SUM_W'(rrpd_pkg::RING_DEPTH)) ?
                    rrpd_pkg::PTR_W'(slot_sum - rrpd_pkg::SUM_W'(rrpd_pkg::RING_DEPTH)) :
                    rrpd_pkg::PTR_W'(slot_sum);
  assign rp_inc   = (rp_r == rrpd_pkg::PTR_W'(rrpd_pkg::RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign fl_dec   = fl_r - 1'b1;
  assign hdr_ok   = rrpd_pkg::header_ok(ram_rdata, debug_address, count_table);

  rrpd_ram #(
    .WIDTH (8),
    .DEPTH (rrpd_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_slot),
    .wr_data (in_byte),
    .rd_addr (rp_nxt),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrpd_pkg::ST_IDLE: begin
        if (accept && (in_action == rrpd_pkg::ACT_PULL) && (fl_r != '0)) begin
          state_nxt = rrpd_pkg::ST_SCAN;
        end
      end
      rrpd_pkg::ST_SCAN: begin
        if (res_valid) begin
          state_nxt = rrpd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // ring and deframer updates
  always_comb begin
    rp_nxt       = rp_r;
    fl_nxt       = fl_r;
    hunting_nxt  = hunting_r;
    cur_addr_nxt = cur_addr_r;
    cur_cnt_nxt  = cur_cnt_r;
    bg_nxt       = bg_r;
    pkt_byte_nxt = pkt_byte_r;
    ram_we       = 1'b0;
    res_valid    = 1'b0;
    done         = 1'b0;
    ovf          = 1'b0;
    unique case (state_r)
      rrpd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == rrpd_pkg::ACT_PUSH) begin
            ram_we    = 1'b1;
            res_valid = 1'b1;
            if (fl_r == rrpd_pkg::LVL_W'(rrpd_pkg::RING_DEPTH)) begin
              fl_nxt = '0;
              ovf    = 1'b1;
            end else begin
              fl_nxt = fl_r + 1'b1;
            end
          end else if (fl_r == '0) begin
            res_valid = 1'b1;
          end
        end
      end
      rrpd_pkg::ST_SCAN: begin
        rp_nxt = rp_inc;
        fl_nxt = fl_dec;
        if (hunting_r) begin
          if (hdr_ok) begin
            cur_addr_nxt = ram_rdata[7:4];
            cur_cnt_nxt  = ram_rdata[2:1];
            bg_nxt       = '0;
            hunting_nxt  = 1'b0;
            if (ram_rdata[2:1] == 2'd0) begin
              done        = 1'b1;
              hunting_nxt = 1'b1;
              res_valid   = 1'b1;
            end else if (fl_dec == '0) begin
              res_valid = 1'b1;
            end
          end else if (fl_dec == '0) begin
            res_valid = 1'b1;
          end
        end else begin
          for (int k = 0; k < rrpd_pkg::PKT_BYTES; k++) begin
            if (bg_r == 2'(k)) begin
              pkt_byte_nxt[k] = ram_rdata;
            end
          end
          bg_nxt = bg_r + 1'b1;
          if ((bg_r + 1'b1) == cur_cnt_r) begin
            done        = 1'b1;
            hunting_nxt = 1'b1;
            res_valid   = 1'b1;
          end else if (fl_dec == '0) begin
            res_valid = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.packet_done    = done;
    res.pkt_address    = cur_addr_nxt;
    res.pkt_count      = cur_cnt_nxt;
    res.pkt_bytes_read = bg_nxt;
    res.pkt_byte0      = (bg_nxt > 2'd0) ? pkt_byte_nxt[0] : 8'h00;
    res.pkt_byte1      = (bg_nxt > 2'd1) ? pkt_byte_nxt[1] : 8'h00;
    res.pkt_byte2      = (bg_nxt > 2'd2) ? pkt_byte_nxt[2] : 8'h00;
    res.fifo_level     = 6'(fl_nxt);
    res.overflowed     = ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rrpd_pkg::ST_IDLE;
      rp_r       <= '0;
      fl_r       <= '0;
      hunting_r  <= 1'b1;
      cur_addr_r <= '0;
      cur_cnt_r  <= '0;
      bg_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      rp_r       <= rp_nxt;
      fl_r       <= fl_nxt;
      hunting_r  <= hunting_nxt;
      cur_addr_r <= cur_addr_nxt;
      cur_cnt_r  <= cur_cnt_nxt;
      bg_r       <= bg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_byte_r <= pkt_byte_nxt;
  end

endmodule

### hdl/rx_ring_packet_deframer.sv
// Receive ring FIFO with header-based packet deframer.
// in_*  : one transaction per item; in_tuser selects push (0) or pull (1),
//         in_tdata carries the received byte for a push.
// out_* : exactly one result transaction per input transaction, in order.
// cfg_* : register writes (index 0 debug address, 1 expected count table),
//         always accepted; write only while the block is idle.
// A push or a pull on an empty ring shows its result in the cycle after
// acceptance. A pull that finds bytes reads the ring one byte per cycle and
// consumes dropped non-headers, the header and data bytes until a packet is
// done or the ring runs empty.
// A new item is taken once the previous one is finished and the output
// register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) empties the ring, clears the state and
// config registers and starts in header hunting. A stalled receiver holds
// the result in the output register and blocks further input until it is taken.
`include "rx_ring_packet_deframer_macros.svh"

module rx_ring_packet_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rrpd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] pkt_address, [5:4] pkt_count, [7:6] pkt_bytes_read, [15:8] pkt_byte0,
  // [23:16] pkt_byte1, [31:24] pkt_byte2, [37:32] fifo_level, [38] overflowed
  output logic [rrpd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,  // [0] packet_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [3:0]     debug_address_r;
  logic [31:0]    count_table_r;
  logic           out_valid_r;
  rrpd_pkg::res_t out_res_r;
  logic           slot_free;
  logic           res_valid;
  rrpd_pkg::res_t res;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debug_address_r <= '0;
      count_table_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rrpd_pkg::CFG_DEBUG_ADDR:  debug_address_r <= cfg_data[3:0];
        rrpd_pkg::CFG_COUNT_TABLE: count_table_r   <= cfg_data;
      endcase
    end
  end

  rrpd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_action     (in_tuser),
    .in_byte       (in_tdata),
    .debug_address (debug_address_r),
    .count_table   (count_table_r),
    .slot_free     (slot_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.packet_done;
  assign out_tdata  = {1'b0, out_res_r.overflowed, out_res_r.fifo_level,
                       out_res_r.pkt_byte2, out_res_r.pkt_byte1, out_res_r.pkt_byte0,
                       out_res_r.pkt_bytes_read, out_res_r.pkt_count,
                       out_res_r.pkt_address};

  `RRPD_ASSERT_NOW(a_ready_needs_slot, in_tready, !out_tvalid || out_tready,
                   "input taken while result register is blocked")
  `RRPD_ASSERT_NEXT(a_push_one_cycle, in_tvalid && in_tready && in_tuser == rrpd_pkg::ACT_PUSH,
                    out_tvalid, "push result not presented next cycle")
  `RRPD_ASSERT_NOW(a_level_bound, out_tvalid,
                   out_tdata[37:32] <= 6'(rrpd_pkg::RING_DEPTH), "fill level beyond ring size")
  `RRPD_ASSERT_NOW(a_ovf_empties, out_tvalid && out_tdata[38],
                   out_tdata[37:32] == 6'd0 && !out_tuser, "overflow without empty ring")
  `RRPD_ASSERT_NOW(a_done_complete, out_tvalid && out_tuser,
                   out_tdata[7:6] == out_tdata[5:4], "packet done with missing bytes")

endmodule
